/* src/rsi_pkg.sv */
// ----------------------------------------------------------------------------
// rsi_pkg - shared definitions for the relative strength index block
// widths, default parameters, result codes and controller states
// ----------------------------------------------------------------------------
package rsi_pkg;

    // default datapath parameters
    localparam int PRICE_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // lookback register
    localparam int                  PERIOD_W     = 8;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd14;

    // result encoding, hundredths of a point
    localparam int               RSI_W       = 14;
    localparam int               OUT_TDATA_W = ((RSI_W + 7) / 8) * 8;
    localparam logic [RSI_W-1:0] RSI_NEUTRAL = 14'd5000;
    localparam logic [RSI_W-1:0] RSI_FULL    = 14'd10000;

    // quotient bits retired per cycle by the period dividers
    localparam int DIV_DIGIT = 2;

    // 10000 = 2^13 + 2^10 + 2^9 + 2^8 + 2^4, one shifted add per term
    localparam int SCALE_TERMS = 5;
    typedef logic [3:0] shift_t;
    localparam shift_t SCALE_SHIFTS [SCALE_TERMS] = '{4'd13, 4'd10, 4'd9, 4'd8, 4'd4};

    // controller states
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_PREP  = 8'b0000_0010,
        ST_DIV   = 8'b0000_0100,
        ST_APPLY = 8'b0000_1000,
        ST_RSUM  = 8'b0001_0000,
        ST_MUL   = 8'b0010_0000,
        ST_RDIV  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

endpackage

/* src/relative_strength_index.sv */
// ----------------------------------------------------------------------------
// relative_strength_index - streaming wilder rsi over a price series
// one price item in, one rsi item out, fixed point averages
// ----------------------------------------------------------------------------

// One price per input item gives one rsi item, in hundredths of a point
// (0..10000) with a warm flag in tuser. The first sample of a series, and the
// following samples until period price changes have been seen, give 5000 with
// warm clear. A warm item goes through two bit-serial dividers that divide the
// gain and loss averages by period, two quotient bits a cycle through an 8-bit
// remainder, then five shifted adds that form 10000*gain and a 14-step restoring
// divider for the ratio; when the average loss is zero the result is 10000
// without the shifted adds and the ratio divider. One item is worked on at a
// time; the result sits in an output register, so the next price is taken while
// it waits for m_tready. Writing period restarts the series and is meant for an
// idle block.
module relative_strength_index #(
    parameter int PRICE_BITS = rsi_pkg::PRICE_BITS_DEF,
    parameter int FRAC_BITS  = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // lookback register write
    input  logic                                cfg_wr_en,
    input  logic [rsi_pkg::PERIOD_W-1:0]        cfg_wr_data,
    // price items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((PRICE_BITS+7)/8)*8-1:0]     s_tdata,   // price, zero padded
    input  logic [0:0]                          s_tuser,   // new_series
    // rsi items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rsi_pkg::OUT_TDATA_W-1:0]     m_tdata,   // rsi_hundredths, zero padded
    output logic [0:0]                          m_tuser    // warm
);
    import rsi_pkg::*;

    // averages carry FRAC_BITS fraction bits; warm-up sums fit as FRAC_BITS >= 8
    localparam int ACC_W     = PRICE_BITS + FRAC_BITS;
    localparam int DIV_STEPS = (ACC_W + DIV_DIGIT - 1) / DIV_DIGIT;
    localparam int SH_W      = DIV_STEPS * DIV_DIGIT;
    localparam int N_W       = SH_W + PERIOD_W;
    localparam int RATIO_W   = ACC_W + 1 + RSI_W;
    localparam int CNT_MAX   = (DIV_STEPS > RSI_W) ? DIV_STEPS : RSI_W;
    localparam int CNT_W     = $clog2(CNT_MAX);
    localparam int SC_IDX_W  = $clog2(SCALE_TERMS);
    localparam int COUNT_W   = PERIOD_W + 1;
    localparam int NUM_CH    = 2;
    localparam int CH_GAIN   = 0;
    localparam int CH_LOSS   = 1;

    // control state
    state_t                 state_reg, state_next;
    logic [PERIOD_W-1:0]    period_reg, period_next;
    logic [PRICE_BITS-1:0]  prev_reg, prev_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [ACC_W-1:0]       avg_reg [NUM_CH];
    logic [ACC_W-1:0]       avg_next [NUM_CH];
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;

    // datapath registers
    logic                   gt_reg, gt_next;
    logic [PRICE_BITS-1:0]  diff_reg, diff_next;
    logic                   seed_reg, seed_next;
    logic [SH_W-1:0]        num_reg [NUM_CH];
    logic [SH_W-1:0]        num_next [NUM_CH];
    logic [PERIOD_W-1:0]    rem_reg [NUM_CH];
    logic [PERIOD_W-1:0]    rem_next [NUM_CH];
    logic                   ge_reg [NUM_CH];
    logic                   ge_next [NUM_CH];
    logic [ACC_W:0]         rden_reg, rden_next;
    logic [RATIO_W-1:0]     ratio_reg, ratio_next;
    logic [RSI_W-1:0]       res_rsi_reg, res_rsi_next;
    logic                   res_warm_reg, res_warm_next;
    logic [RSI_W-1:0]       out_rsi_reg, out_rsi_next;
    logic                   out_warm_reg, out_warm_next;

    // combinational helpers
    logic [PERIOD_W-1:0]    p_eff;
    logic [COUNT_W-1:0]     p_wide;
    logic [PRICE_BITS-1:0]  in_price;
    logic                   in_gt;
    logic [PRICE_BITS-1:0]  in_diff;
    logic [PRICE_BITS-1:0]  x_c [NUM_CH];
    logic [ACC_W-1:0]       sum_c [NUM_CH];
    logic [ACC_W-1:0]       xs_c [NUM_CH];
    logic                   ge_c [NUM_CH];
    logic [ACC_W-1:0]       mag_c [NUM_CH];
    logic [N_W-1:0]         seed_c [NUM_CH];
    logic [N_W-1:0]         load_c [NUM_CH];
    logic [SH_W-1:0]        div_num [NUM_CH];
    logic [PERIOD_W-1:0]    div_rem [NUM_CH];
    logic [ACC_W-1:0]       applied_c [NUM_CH];
    logic [ACC_W+1:0]       ratio_trial;
    logic                   ratio_ge;
    logic [ACC_W:0]         ratio_top;
    logic [RATIO_W-1:0]     ratio_step;
    logic [RATIO_W-1:0]     mul_term;

    // a period of zero behaves as one
    assign p_eff  = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
    assign p_wide = {1'b0, p_eff};

    // price change of the incoming item, split by direction
    assign in_price = s_tdata[PRICE_BITS-1:0];
    assign in_gt    = in_price > prev_reg;
    assign in_diff  = in_gt ? (in_price - prev_reg) : (prev_reg - in_price);

    assign s_tready = (state_reg == ST_IDLE);

    // operand set-up for the gain lane and the loss lane
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            x_c[c]   = (((c == CH_GAIN) ? 1'b1 : 1'b0) == gt_reg) ? diff_reg : '0;
            sum_c[c] = avg_reg[c] + ACC_W'(x_c[c]);
            xs_c[c]  = ACC_W'(x_c[c]) << FRAC_BITS;
            ge_c[c]  = xs_c[c] >= avg_reg[c];
            mag_c[c] = ge_c[c] ? (xs_c[c] - avg_reg[c]) : (avg_reg[c] - xs_c[c]);
            // seeding divides sum * 2^FRAC_BITS, smoothing divides |x - avg|
            seed_c[c] = N_W'(sum_c[c]) << FRAC_BITS;
            load_c[c] = (count_reg == p_wide) ? seed_c[c] : N_W'(mag_c[c]);
        end
    end

    // one digit of restoring division by period in each lane
    always_comb
    begin : div_digit
        logic [PERIOD_W:0] trial;
        trial = '0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            div_rem[c] = rem_reg[c];
            div_num[c] = num_reg[c];
            for (int k = 0; k < DIV_DIGIT; k++)
            begin
                trial      = {div_rem[c], div_num[c][SH_W-1]};
                div_num[c] = {div_num[c][SH_W-2:0], 1'b0};
                if (trial >= p_wide)
                begin
                    div_rem[c]    = PERIOD_W'(trial - p_wide);
                    div_num[c][0] = 1'b1;
                end
                else
                begin
                    div_rem[c] = trial[PERIOD_W-1:0];
                end
            end
        end
    end

    // new averages from the quotients; a falling average rounds the step up
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (seed_reg)
                applied_c[c] = num_reg[c][ACC_W-1:0];
            else if (ge_reg[c])
                applied_c[c] = avg_reg[c] + num_reg[c][ACC_W-1:0];
            else
                applied_c[c] = avg_reg[c] - num_reg[c][ACC_W-1:0]
                               - ACC_W'(rem_reg[c] != '0);
        end
    end

    // ratio divider: remainder in the upper bits, quotient shifts in below
    assign ratio_trial = ratio_reg[RATIO_W-1:RSI_W-1];
    assign ratio_ge    = ratio_trial >= {1'b0, rden_reg};
    assign ratio_top   = ratio_ge ? (ACC_W+1)'(ratio_trial - {1'b0, rden_reg})
                                  : ratio_trial[ACC_W:0];
    assign ratio_step  = {ratio_top, ratio_reg[RSI_W-2:0], ratio_ge};

    // one term of 10000 * gain average
    assign mul_term = RATIO_W'(avg_reg[CH_GAIN]) << SCALE_SHIFTS[cnt_reg[SC_IDX_W-1:0]];

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        period_next    = period_reg;
        prev_next      = prev_reg;
        count_next     = count_reg;
        cnt_next       = cnt_reg;
        gt_next        = gt_reg;
        diff_next      = diff_reg;
        seed_next      = seed_reg;
        rden_next      = rden_reg;
        ratio_next     = ratio_reg;
        res_rsi_next   = res_rsi_reg;
        res_warm_next  = res_warm_reg;
        out_rsi_next   = out_rsi_reg;
        out_warm_next  = out_warm_reg;
        out_valid_next = out_valid_reg && !m_tready;
        for (int c = 0; c < NUM_CH; c++)
        begin
            avg_next[c] = avg_reg[c];
            num_next[c] = num_reg[c];
            rem_next[c] = rem_reg[c];
            ge_next[c]  = ge_reg[c];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    prev_next = in_price;
                    if (s_tuser[0] || (count_reg == '0))
                    begin
                        // first sample of a series records the price and clears the averages
                        count_next = COUNT_W'(1);
                        for (int c = 0; c < NUM_CH; c++)
                            avg_next[c] = '0;
                        res_rsi_next  = RSI_NEUTRAL;
                        res_warm_next = 1'b0;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        gt_next    = in_gt;
                        diff_next  = in_diff;
                        state_next = ST_PREP;
                    end
                end
            end

            ST_PREP:
            begin
                if (count_reg < p_wide)
                begin
                    // warm-up: plain integer sums
                    for (int c = 0; c < NUM_CH; c++)
                        avg_next[c] = sum_c[c];
                    count_next    = count_reg + COUNT_W'(1);
                    res_rsi_next  = RSI_NEUTRAL;
                    res_warm_next = 1'b0;
                    state_next    = ST_DONE;
                end
                else
                begin
                    // dividend top bits are always below period
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        num_next[c] = load_c[c][SH_W-1:0];
                        rem_next[c] = load_c[c][N_W-1:SH_W];
                        ge_next[c]  = ge_c[c];
                    end
                    seed_next     = (count_reg == p_wide);
                    count_next    = p_wide + COUNT_W'(1);
                    res_warm_next = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_DIV;
                end
            end

            ST_DIV:
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    num_next[c] = div_num[c];
                    rem_next[c] = div_rem[c];
                end
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_APPLY;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_APPLY:
            begin
                for (int c = 0; c < NUM_CH; c++)
                    avg_next[c] = applied_c[c];
                state_next = ST_RSUM;
            end

            ST_RSUM:
            begin
                if (avg_reg[CH_LOSS] == '0)
                begin
                    res_rsi_next = RSI_FULL;
                    state_next   = ST_DONE;
                end
                else
                begin
                    rden_next  = {1'b0, avg_reg[CH_GAIN]} + {1'b0, avg_reg[CH_LOSS]};
                    ratio_next = '0;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                ratio_next = ratio_reg + mul_term;
                if (cnt_reg == CNT_W'(SCALE_TERMS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_RDIV;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_RDIV:
            begin
                ratio_next = ratio_step;
                if (cnt_reg == CNT_W'(RSI_W - 1))
                begin
                    res_rsi_next = ratio_step[RSI_W-1:0];
                    cnt_next     = '0;
                    state_next   = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_DONE:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_rsi_next   = res_rsi_reg;
                    out_warm_next  = res_warm_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a new period restarts the series
        if (cfg_wr_en)
        begin
            period_next = cfg_wr_data;
            count_next  = '0;
            for (int c = 0; c < NUM_CH; c++)
                avg_next[c] = '0;
        end
    end

    // control and series state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            period_reg    <= PERIOD_RESET;
            prev_reg      <= '0;
            count_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CH; c++)
                avg_reg[c] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            period_reg    <= period_next;
            prev_reg      <= prev_next;
            count_reg     <= count_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            for (int c = 0; c < NUM_CH; c++)
                avg_reg[c] <= avg_next[c];
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        gt_reg       <= gt_next;
        diff_reg     <= diff_next;
        seed_reg     <= seed_next;
        rden_reg     <= rden_next;
        ratio_reg    <= ratio_next;
        res_rsi_reg  <= res_rsi_next;
        res_warm_reg <= res_warm_next;
        out_rsi_reg  <= out_rsi_next;
        out_warm_reg <= out_warm_next;
        for (int c = 0; c < NUM_CH; c++)
        begin
            num_reg[c] <= num_next[c];
            rem_reg[c] <= rem_next[c];
            ge_reg[c]  <= ge_next[c];
        end
    end

    // result item
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = OUT_TDATA_W'(out_rsi_reg);
    assign m_tuser[0] = out_warm_reg;

    // period divider remainders stay below the divisor
    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> ((rem_reg[CH_GAIN] < p_eff) && (rem_reg[CH_LOSS] < p_eff)))
        else $error("period divider remainder not below period");

    // ratio divider remainder stays below gain plus loss
    a_ratio_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RDIV) |-> (ratio_reg[RATIO_W-1:RSI_W] < rden_reg))
        else $error("ratio divider remainder not below denominator");

    // a result that is not warm is the neutral value
    a_cold_neutral: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == OUT_TDATA_W'(RSI_NEUTRAL)))
        else $error("cold result is not neutral");

    // rsi never exceeds a full scale
    a_rsi_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata <= OUT_TDATA_W'(RSI_FULL)))
        else $error("rsi above full scale");

    // sample count saturates one past the period
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (p_wide + COUNT_W'(1)))
        else $error("sample count beyond period plus one");

endmodule

/* test/rsi_checker.sv */
// ----------------------------------------------------------------------------
// rsi_checker - scoreboard for the relative strength index block
// watches both streams and the lookback writes, predicts every rsi item
// and compares it field by field with what the block sends
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsi_checker #(
    parameter int PRICE_BITS = rsi_pkg::PRICE_BITS_DEF,
    parameter int FRAC_BITS  = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [rsi_pkg::PERIOD_W-1:0]    cfg_wr_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [((PRICE_BITS+7)/8)*8-1:0] s_tdata,   // price, zero padded
    input  logic [0:0]                      s_tuser,   // new_series
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    output int                              fail_count,
    output int                              outstanding,
    input  logic [rsi_pkg::OUT_TDATA_W-1:0] m_tdata,   // rsi_hundredths, zero padded
    input  logic [0:0]                      m_tuser    // warm
);
    import rsi_pkg::*;

    typedef struct packed {
        logic [OUT_TDATA_W-1:0] rsi;
        logic                   warm;
    } rsi_item_t;

    // predicted block state
    logic [PERIOD_W-1:0] lookback;
    logic [63:0]         last_price;
    int unsigned         seen_count;
    logic [63:0]         gain_avg;
    logic [63:0]         loss_avg;

    rsi_item_t rsi_expected_q[$];

    // avg + floor((X-avg)/n) upwards, avg - ceil((avg-X)/n) downwards
    function automatic logic [63:0] wilder_smooth(logic [63:0] avg, logic [63:0] change,
                                                  logic [63:0] div);
        logic [63:0] scaled;
        scaled = change << FRAC_BITS;
        if (scaled >= avg)
            return avg + (scaled - avg) / div;
        return avg - ((avg - scaled) + div - 64'd1) / div;
    endfunction

    // floor(10000*G/(G+L)), full scale when no loss
    function automatic logic [OUT_TDATA_W-1:0] strength_ratio(logic [63:0] g, logic [63:0] l);
        logic [95:0] num;
        logic [95:0] den;
        if (l == 64'd0)
            return OUT_TDATA_W'(RSI_FULL);
        num = 96'(g) * 96'd10000;
        den = 96'(g) + 96'(l);
        return OUT_TDATA_W'(num / den);
    endfunction

    task automatic track_price(input logic [63:0] raw, input logic restart,
                               output rsi_item_t res);
        logic [63:0] price;
        logic [63:0] gain;
        logic [63:0] loss;
        logic [63:0] div;
        price = raw & ((64'd1 << PRICE_BITS) - 64'd1);
        div   = (lookback == '0) ? 64'd1 : 64'(lookback);
        gain  = 64'd0;
        loss  = 64'd0;
        res.rsi  = OUT_TDATA_W'(RSI_NEUTRAL);
        res.warm = 1'b0;
        if (restart)
        begin
            seen_count = 0;
            gain_avg   = 64'd0;
            loss_avg   = 64'd0;
        end
        if (seen_count == 0)
            seen_count = 1;
        else
        begin
            if (price > last_price)
                gain = price - last_price;
            else
                loss = last_price - price;
            if (64'(seen_count) < div)
            begin
                gain_avg   = gain_avg + gain;
                loss_avg   = loss_avg + loss;
                seen_count = seen_count + 1;
            end
            else
            begin
                if (64'(seen_count) == div)
                begin
                    // seed with the mean of the warm-up changes
                    gain_avg   = ((gain_avg + gain) << FRAC_BITS) / div;
                    loss_avg   = ((loss_avg + loss) << FRAC_BITS) / div;
                    seen_count = int'(div) + 1;
                end
                else
                begin
                    gain_avg = wilder_smooth(gain_avg, gain, div);
                    loss_avg = wilder_smooth(loss_avg, loss, div);
                end
                res.rsi  = strength_ratio(gain_avg, loss_avg);
                res.warm = 1'b1;
            end
        end
        last_price = price;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsi_item_t got;
        rsi_item_t want;
        if (!rst_n)
        begin
            lookback   = PERIOD_RESET;
            last_price = 64'd0;
            seen_count = 0;
            gain_avg   = 64'd0;
            loss_avg   = 64'd0;
            rsi_expected_q.delete();
            outstanding = 0;
            fail_count  = 0;
        end
        else
        begin
            // a lookback write restarts the series
            if (cfg_wr_en)
            begin
                lookback   = cfg_wr_data;
                seen_count = 0;
                gain_avg   = 64'd0;
                loss_avg   = 64'd0;
            end
            if (m_tvalid && m_tready)
            begin
                got.rsi  = m_tdata;
                got.warm = m_tuser[0];
                if (rsi_expected_q.size() == 0)
                begin
                    $error("unexpected rsi item: rsi_hundredths %0d warm %0d",
                           got.rsi, got.warm);
                    fail_count++;
                end
                else
                begin
                    want = rsi_expected_q.pop_front();
                    if (got.rsi !== want.rsi)
                    begin
                        $error("rsi_hundredths mismatch: expected %0d, actual %0d",
                               want.rsi, got.rsi);
                        fail_count++;
                    end
                    if (got.warm !== want.warm)
                    begin
                        $error("warm mismatch: expected %0d, actual %0d",
                               want.warm, got.warm);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                track_price(64'(s_tdata), s_tuser[0], want);
                rsi_expected_q.push_back(want);
            end
            outstanding = rsi_expected_q.size();
        end
    end

endmodule

/* test/tb_relative_strength_index.sv */
// ----------------------------------------------------------------------------
// tb_relative_strength_index - testbench for the relative strength index block
// directed price runs over several lookbacks, then random walks with restarts,
// random idling on both streams, a long output hold and a drain pause
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_relative_strength_index;

    import rsi_pkg::*;

    localparam int PRICE_BITS = PRICE_BITS_DEF;
    localparam int FRAC_BITS  = FRAC_BITS_DEF;
    localparam int PRICE_W    = ((PRICE_BITS + 7) / 8) * 8;
    localparam int IDLE_PCT   = 23;
    // output hold long enough for the block to fill up and stall its input
    localparam int LONG_HOLD  = 300;
    localparam int PHASES     = 8;

    // every block input has a known value from time zero
    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [PERIOD_W-1:0]    cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [PRICE_W-1:0]     s_tdata     = '0;    // price, zero padded
    logic [0:0]             s_tuser     = '0;    // new_series
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;             // rsi_hundredths, zero padded
    logic [0:0]             m_tuser;             // warm

    int fail_count;
    int outstanding;

    // random idling switch, and long hold requests served by the receiver
    bit idle_on     = 1'b1;
    int holds_asked = 0;
    int holds_done  = 0;
    int hold_left   = 0;

    // random walk state for the price series
    logic [31:0] walk_price = '0;
    int          walk_bias  = 50;
    int          walk_mag   = 255;

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    relative_strength_index #(
        .PRICE_BITS (PRICE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // scoreboard beside the block, it only watches
    rsi_checker #(
        .PRICE_BITS (PRICE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // receiver: random back-pressure, or a long counted hold on request
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_done != holds_asked)
        begin
            m_tready   <= 1'b0;
            hold_left  <= LONG_HOLD;
            holds_done <= holds_done + 1;
        end
        else
            m_tready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // offer one price item, with random gaps before it, until it is taken
    task automatic send_price(input logic [31:0] price, input logic restart);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= PRICE_W'(price);
        s_tuser  <= restart;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // stop offering and wait until every predicted rsi item has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        // sample on the falling edge, away from the checker's updates
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // lookback writes only on an idle block
    task automatic write_lookback(input logic [PERIOD_W-1:0] value);
        drain_results();
        repeat (8) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // next price of a random walk; restart_pm is the restart chance per mille
    task automatic next_walk_price(input int restart_pm, output logic [31:0] price,
                                   output logic restart);
        int kind;
        int step;
        restart = ($urandom_range(0, 999) < restart_pm);
        if (restart)
        begin
            // fresh series with its own trend and volatility
            walk_price = $urandom;
            walk_bias  = $urandom_range(0, 100);
            case ($urandom_range(0, 2))
                0:       walk_mag = 3;
                1:       walk_mag = 255;
                default: walk_mag = 65535;
            endcase
        end
        kind = $urandom_range(0, 99);
        if (kind < 5)
            walk_price = $urandom;            // wild jump, any bit pattern
        else if (kind >= 15)
        begin
            step = $urandom_range(0, walk_mag);
            if ($urandom_range(0, 99) < walk_bias)
                walk_price = walk_price + 32'(step);
            else
                walk_price = walk_price - 32'(step);
        end
        // otherwise a flat sample, no change at all
        price = walk_price;
    endtask

    // stimulus
    initial
    begin : stimulus
        logic [PERIOD_W-1:0] lookbacks [PHASES];
        int                  counts    [PHASES];
        logic [31:0]         price;
        logic                restart;
        int                  restart_pm;

        lookbacks = '{8'd14, 8'd1, 8'd255, 8'd0, 8'd2, 8'd5, 8'd0, 8'd0};
        counts    = '{120, 100, 320, 80, 100, 120, 130, 130};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short lookback so warm-up ends quickly
        write_lookback(8'd3);
        send_price(32'd0, 1'b1);              // first sample carries a restart
        send_price(32'd0, 1'b0);
        send_price(32'd0, 1'b0);
        send_price(32'd0, 1'b0);              // warm, both averages zero
        send_price(32'hFFFF_FFFF, 1'b0);      // largest gain
        send_price(32'd0, 1'b0);              // largest loss
        send_price(32'hFFFF_FFFF, 1'b0);
        send_price(32'd5, 1'b0);
        send_price(32'd100, 1'b1);            // restart in mid series
        send_price(32'd101, 1'b0);
        send_price(32'd102, 1'b0);
        send_price(32'd103, 1'b0);            // only gains, full scale
        send_price(32'd50, 1'b0);
        send_price(32'd0, 1'b0);
        send_price(32'd0, 1'b0);

        // lookback of one, warm from the second sample
        write_lookback(8'd1);
        send_price(32'd7, 1'b0);
        send_price(32'd9, 1'b0);
        send_price(32'd3, 1'b0);
        send_price(32'd3, 1'b0);

        // lookback zero behaves as one
        write_lookback(8'd0);
        send_price(32'd0, 1'b0);
        send_price(32'hFFFF_FFFF, 1'b0);
        send_price(32'hFFFF_FFFF, 1'b0);
        send_price(32'h8000_0000, 1'b0);

        // random walks over several lookbacks, the extremes among them
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph >= 6)
                lookbacks[ph] = PERIOD_W'($urandom_range(1, 255));
            write_lookback(lookbacks[ph]);
            // restarts stay rare at the longest lookback so it still warms up
            restart_pm = (lookbacks[ph] > 8'd100) ? 1 : 25;
            // one phase runs flat out on both sides
            idle_on = (ph != 5);
            for (int n = 0; n < counts[ph]; n++)
            begin
                // hold the output while prices keep coming, so the input stalls
                if (ph == 2 && n == 20)
                    holds_asked = holds_asked + 1;
                // sender pause until the block has handed back everything
                if (ph == 6 && n == 60)
                    drain_results();
                next_walk_price(restart_pm, price, restart);
                send_price(price, restart);
            end
        end
        idle_on = 1'b1;

        // let the last items come out, then a margin for strays
        drain_results();
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
src/rsi_pkg.sv
src/relative_strength_index.sv
test/rsi_checker.sv
test/tb_relative_strength_index.sv
